FILE: sv/mlu_pkg.sv
// Shared types and constants for the motor lattice update block.
// No dependencies; used by mlu_ctrl and motor_lattice_update.
package mlu_pkg;

  localparam int RATE_W    = 20;
  localparam int LEN_W     = 14;
  localparam int IDX_W     = 6;
  localparam int POS_OUT_W = 13;
  localparam int CFG_IDX_W = 2;

  localparam int MOTOR_COUNT_DEF  = 64;
  localparam int LATTICE_SIZE_DEF = 8192;
  localparam int START_OFFSET_DEF = 3000;
  localparam int LEN_RESET        = 8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_RATE   = 2'd0,
    REG_OFF_RATE  = 2'd1,
    REG_STEP_RATE = 2'd2,
    REG_LAT_LEN   = 2'd3
  } cfg_reg_t;

  // len_sat is the lattice length already clipped to the lattice size
  typedef struct packed {
    logic [RATE_W-1:0] on_rate;
    logic [RATE_W-1:0] off_rate;
    logic [RATE_W-1:0] step_rate;
    logic [LEN_W-1:0]  len_sat;
  } cfg_t;

endpackage

FILE: sv/motor_lattice_update.sv
// Top level of the motor lattice update: configuration registers, motor record
// RAM, site occupancy RAM and the update sequencer. Depends on mlu_pkg, mlu_ram, mlu_ctrl.
//
//   port group  direction  handshake            payload
//   in_*        input      in_valid/in_ready    motor_index, draw_a, draw_b
//   out_*       output     out_valid/out_ready  acted_motor, new_position, now_bound,
//                                               bind_toggled, advanced
//   cfg_*       input      cfg_we               cfg_index, cfg_wdata
//
// Each transaction runs as a motor record read, then the dependent site read,
// then decide and write back; the second site write of a step overlaps the
// next accept. After reset a clearing pass over all LATTICE_SIZE sites and
// MOTOR_COUNT records builds the initial lattice with in_ready low. A stalled
// result holds the sequencer in its decide step; one finished result may wait
// while the next transaction is taken in.
module motor_lattice_update #(
  parameter int MOTOR_COUNT  = mlu_pkg::MOTOR_COUNT_DEF,
  parameter int LATTICE_SIZE = mlu_pkg::LATTICE_SIZE_DEF,
  parameter int START_OFFSET = mlu_pkg::START_OFFSET_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mlu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlu_pkg::RATE_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mlu_pkg::IDX_W-1:0]       in_motor_index,
  input  logic [mlu_pkg::RATE_W-1:0]      in_draw_a,
  input  logic [mlu_pkg::RATE_W-1:0]      in_draw_b,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mlu_pkg::IDX_W-1:0]       out_acted_motor,
  output logic [mlu_pkg::POS_OUT_W-1:0]   out_new_position,
  output logic                            out_now_bound,
  output logic                            out_bind_toggled,
  output logic                            out_advanced
);

  localparam int MW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int PW = $clog2(LATTICE_SIZE);
  localparam int LW = mlu_pkg::LEN_W;
  localparam logic [LW-1:0] LEN_RST =
    LW'((LATTICE_SIZE < mlu_pkg::LEN_RESET) ? LATTICE_SIZE : mlu_pkg::LEN_RESET);

  mlu_pkg::cfg_t cfg_r, cfg_nxt;
  logic [LW-1:0] len_in, len_sat;

  assign len_in  = cfg_wdata[LW-1:0];
  assign len_sat = (32'(len_in) > LATTICE_SIZE) ? LW'(LATTICE_SIZE) : len_in;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (mlu_pkg::cfg_reg_t'(cfg_index))
        mlu_pkg::REG_ON_RATE:   cfg_nxt.on_rate   = cfg_wdata;
        mlu_pkg::REG_OFF_RATE:  cfg_nxt.off_rate  = cfg_wdata;
        mlu_pkg::REG_STEP_RATE: cfg_nxt.step_rate = cfg_wdata;
        mlu_pkg::REG_LAT_LEN:   cfg_nxt.len_sat   = len_sat;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_rate   <= '0;
      cfg_r.off_rate  <= '0;
      cfg_r.step_rate <= '0;
      cfg_r.len_sat   <= LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  logic          m_we, m_re;
  logic [MW-1:0] m_waddr, m_raddr;
  logic [PW:0]   m_wdata, m_rdata;
  logic          s_we, s_re, s_wdata, s_rdata;
  logic [PW-1:0] s_waddr, s_raddr;

  mlu_ram #(
    .DEPTH (MOTOR_COUNT),
    .AW    (MW),
    .DW    (PW + 1)
  ) u_motor_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  mlu_ram #(
    .DEPTH (LATTICE_SIZE),
    .AW    (PW),
    .DW    (1)
  ) u_site_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  mlu_ctrl #(
    .MOTOR_COUNT  (MOTOR_COUNT),
    .LATTICE_SIZE (LATTICE_SIZE),
    .START_OFFSET (START_OFFSET),
    .MW           (MW),
    .PW           (PW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_motor_index   (in_motor_index),
    .in_draw_a        (in_draw_a),
    .in_draw_b        (in_draw_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_acted_motor  (out_acted_motor),
    .out_new_position (out_new_position),
    .out_now_bound    (out_now_bound),
    .out_bind_toggled (out_bind_toggled),
    .out_advanced     (out_advanced),
    .m_we             (m_we),
    .m_waddr          (m_waddr),
    .m_wdata          (m_wdata),
    .m_re             (m_re),
    .m_raddr          (m_raddr),
    .m_rdata          (m_rdata),
    .s_we             (s_we),
    .s_waddr          (s_waddr),
    .s_wdata          (s_wdata),
    .s_re             (s_re),
    .s_raddr          (s_raddr),
    .s_rdata          (s_rdata)
  );

endmodule

FILE: sv/mlu_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; holds the motor records and the site occupancy bits.
module mlu_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/mlu_ctrl.sv
// Update sequencer: reset sweep, record read, site read, decide and write back,
// plus the result register. Depends on mlu_pkg; drives two mlu_ram instances.
module mlu_ctrl #(
  parameter int MOTOR_COUNT  = mlu_pkg::MOTOR_COUNT_DEF,
  parameter int LATTICE_SIZE = mlu_pkg::LATTICE_SIZE_DEF,
  parameter int START_OFFSET = mlu_pkg::START_OFFSET_DEF,
  parameter int MW           = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1,
  parameter int PW           = $clog2(LATTICE_SIZE)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mlu_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mlu_pkg::IDX_W-1:0]       in_motor_index,
  input  logic [mlu_pkg::RATE_W-1:0]      in_draw_a,
  input  logic [mlu_pkg::RATE_W-1:0]      in_draw_b,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mlu_pkg::IDX_W-1:0]       out_acted_motor,
  output logic [mlu_pkg::POS_OUT_W-1:0]   out_new_position,
  output logic                            out_now_bound,
  output logic                            out_bind_toggled,
  output logic                            out_advanced,
  output logic                            m_we,
  output logic [MW-1:0]                   m_waddr,
  output logic [PW:0]                     m_wdata,
  output logic                            m_re,
  output logic [MW-1:0]                   m_raddr,
  input  logic [PW:0]                     m_rdata,
  output logic                            s_we,
  output logic [PW-1:0]                   s_waddr,
  output logic                            s_wdata,
  output logic                            s_re,
  output logic [PW-1:0]                   s_raddr,
  input  logic                            s_rdata
);

  localparam int IW = mlu_pkg::IDX_W;
  localparam int OW = mlu_pkg::POS_OUT_W;
  localparam int RW = mlu_pkg::RATE_W;
  localparam logic [PW-1:0] INIT_POS0  = PW'(START_OFFSET % LATTICE_SIZE);
  localparam logic [PW-1:0] SITE_LAST  = PW'(LATTICE_SIZE - 1);
  localparam logic [MW-1:0] MOTOR_LAST = MW'(MOTOR_COUNT - 1);

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_INIT = 6'b000010,
    ST_IDLE = 6'b000100,
    ST_SITE = 6'b001000,
    ST_DEC  = 6'b010000,
    ST_WR2  = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [PW-1:0]   site_cnt_r, site_cnt_nxt;
  logic [MW-1:0]   motor_cnt_r, motor_cnt_nxt;
  logic [PW-1:0]   init_pos_r, init_pos_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [MW-1:0]   idx_r;
  logic [IW-1:0]   motor_idx_r;
  logic            idx_ok_r;
  logic [RW-1:0]   da_r, db_r;
  logic [PW-1:0]   pos_r;
  logic            bound_r;
  logic            step_ok_r;
  logic [IW-1:0]   out_motor_r;
  logic [OW-1:0]   out_pos_r;
  logic            out_bound_r, out_tog_r, out_adv_r;

  logic [IW+MW-1:0] idx_ext;
  logic [PW+OW-1:0] pos_ext;
  logic            accept, dec_go;
  logic            bind_c, unbind_c, adv_c, tog_c;
  logic [PW-1:0]   pos_inc, new_pos_c;

  assign in_ready = (state_r == ST_IDLE) || (state_r == ST_WR2);
  assign accept   = in_valid && in_ready;
  assign dec_go   = (state_r == ST_DEC) && (!out_valid_r || out_ready);
  assign idx_ext  = {{MW{1'b0}}, in_motor_index};

  assign bind_c    = idx_ok_r && !bound_r && (da_r < cfg.on_rate);
  assign unbind_c  = idx_ok_r && bound_r && (da_r < cfg.off_rate);
  assign adv_c     = idx_ok_r && bound_r && step_ok_r && !s_rdata && (db_r < cfg.step_rate);
  assign tog_c     = bind_c || unbind_c;
  assign pos_inc   = pos_r + 1'b1;
  assign new_pos_c = adv_c ? pos_inc : pos_r;
  assign pos_ext   = {{OW{1'b0}}, new_pos_c};

  assign m_re    = accept;
  assign m_raddr = idx_ext[MW-1:0];
  assign s_re    = (state_r == ST_SITE);
  assign s_raddr = m_rdata[PW-1:0] + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    site_cnt_nxt  = site_cnt_r;
    motor_cnt_nxt = motor_cnt_r;
    init_pos_nxt  = init_pos_r;
    out_valid_nxt = out_valid_r;
    m_we    = 1'b0;
    m_waddr = idx_r;
    m_wdata = {bound_r ^ tog_c, new_pos_c};
    s_we    = 1'b0;
    s_waddr = pos_r;
    s_wdata = bind_c;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLR: begin
        s_we    = 1'b1;
        s_waddr = site_cnt_r;
        s_wdata = 1'b0;
        site_cnt_nxt = site_cnt_r + 1'b1;
        if (site_cnt_r == SITE_LAST) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        m_we    = 1'b1;
        m_waddr = motor_cnt_r;
        m_wdata = {1'b1, init_pos_r};
        s_we    = 1'b1;
        s_waddr = init_pos_r;
        s_wdata = 1'b1;
        motor_cnt_nxt = motor_cnt_r + 1'b1;
        init_pos_nxt  = (init_pos_r == SITE_LAST) ? '0 : init_pos_r + 1'b1;
        if (motor_cnt_r == MOTOR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SITE;
        end
      end
      ST_SITE: begin
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        if (dec_go) begin
          m_we = tog_c || adv_c;
          s_we = tog_c || adv_c;
          out_valid_nxt = 1'b1;
          state_nxt = adv_c ? ST_WR2 : ST_IDLE;
        end
      end
      ST_WR2: begin
        s_we    = 1'b1;
        s_waddr = pos_inc;
        s_wdata = 1'b1;
        state_nxt = accept ? ST_SITE : ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      site_cnt_r  <= '0;
      motor_cnt_r <= '0;
      init_pos_r  <= INIT_POS0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      site_cnt_r  <= site_cnt_nxt;
      motor_cnt_r <= motor_cnt_nxt;
      init_pos_r  <= init_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r       <= idx_ext[MW-1:0];
      motor_idx_r <= in_motor_index;
      idx_ok_r    <= 32'(in_motor_index) < MOTOR_COUNT;
      da_r        <= in_draw_a;
      db_r        <= in_draw_b;
    end
    if (state_r == ST_SITE) begin
      pos_r     <= m_rdata[PW-1:0];
      bound_r   <= m_rdata[PW];
      step_ok_r <= (32'(m_rdata[PW-1:0]) + 32'd1) < 32'(cfg.len_sat);
    end
    if (dec_go) begin
      out_motor_r <= motor_idx_r;
      out_pos_r   <= idx_ok_r ? pos_ext[OW-1:0] : '0;
      out_bound_r <= idx_ok_r && (bound_r ^ tog_c);
      out_tog_r   <= tog_c;
      out_adv_r   <= adv_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_acted_motor  = out_motor_r;
  assign out_new_position = out_pos_r;
  assign out_now_bound    = out_bound_r;
  assign out_bind_toggled = out_tog_r;
  assign out_advanced     = out_adv_r;

`ifndef ASSERT_OFF
  a_accept_to_site: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SITE)
    else $error("accepted transaction did not start a record read");

  a_wr2_after_dec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR2 |-> $past(state_r) == ST_DEC && out_valid_r && out_adv_r)
    else $error("second site write without a step result");

  a_wr2_free_site: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR2 |-> !s_rdata && s_we && s_wdata)
    else $error("step into an occupied site");

  a_no_write_in_site: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SITE |-> !m_we && !s_we)
    else $error("memory write during record read");

  a_result_from_dec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DEC)
    else $error("result appeared outside the decide step");
`endif

endmodule
